/* design/sdc_pkg.sv */
// Shared types and constants for the synthesizer divider word calculator.
// No dependencies; every other design file refers to it by scoped names.
package sdc_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int FREQ_W     = 32;
    localparam int STEP_W     = 27;
    localparam int INT_W      = 8;
    localparam int HALF_W     = 10;
    localparam int BAND_W     = 2;
    localparam int NUM_EDGES  = 5;
    localparam int NUM_BANDS  = NUM_EDGES - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // One quotient bit per cell over the whole dividend f << FRAC_BITS.
    localparam int DIV_STEPS  = FREQ_W + FRAC_BITS;
    // Partial remainder: one bit above the divisor.
    localparam int REM_W      = STEP_W + 1;
    // Low quotient bits that reach the outputs.
    localparam int Q_KEEP     = (FRAC_BITS + INT_W > 2 * HALF_W) ?
                                (FRAC_BITS + INT_W) : (2 * HALF_W);
    // Front register, one register per cell, output register.
    localparam int LATENCY    = DIV_STEPS + 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PLL_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_4   = 3'd5;

    localparam logic [STEP_W-1:0] PLL_STEP_RST = 27'd30000000;
    localparam logic [FREQ_W-1:0] EDGE_0_RST   = 32'd2300000000;
    localparam logic [FREQ_W-1:0] EDGE_1_RST   = 32'd2400000000;
    localparam logic [FREQ_W-1:0] EDGE_2_RST   = 32'd2500000000;
    localparam logic [FREQ_W-1:0] EDGE_3_RST   = 32'd2600000000;
    localparam logic [FREQ_W-1:0] EDGE_4_RST   = 32'd2700000000;

    typedef logic [NUM_EDGES-1:0][FREQ_W-1:0] edges_t;

    // Payload that travels down the divider chain with each beat.
    typedef struct packed {
        logic              ok;
        logic [BAND_W-1:0] band;
        logic [FREQ_W-1:0] num;   // dividend bits not yet consumed, MSB next
        logic [REM_W-1:0]  rem;   // partial remainder
        logic [Q_KEEP-1:0] quo;   // low quotient bits so far
    } stage_t;

endpackage

/* design/synth_divider_calc_core.sv */
// Top level of the synthesizer divider word calculator.
// Depends on sdc_pkg, sdc_band_sel and sdc_div_cell.
//
// Usage:
//   Input channel: drive lo_freq_hz and raise start; a beat is taken at each
//   rising edge with start high and busy low. busy stays low, so a new
//   frequency may be offered in every cycle.
//   Result channel: done is high for exactly one cycle per accepted beat,
//   with in_range, band_code, int_divider, frac_high and frac_low valid in
//   that same cycle. Results leave in the order the beats came in.
//   Path: a beat taken passes the front band register, the 52 divider cells
//   and the output register, in that order, before its result shows on done.
//   Throughput: one beat per cycle; the row of 52 division cells, one
//   quotient bit each, holds up to 52 beats in flight.
//   The receiver cannot stall: results are not held, so sample them on done.
//   Configuration: write pll_step_hz (index 0) and band_edge_0..4 (index
//   1..5) through cfg_we/cfg_index/cfg_data while no beat is in flight;
//   indexes above 5 are dropped. A zero step yields an all-ones divider.
//   Reset (rst_n low, asynchronous): empty the pipeline, load the default
//   step of 30 MHz and band edges 2.3/2.4/2.5/2.6/2.7 GHz.
module synth_divider_calc_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [sdc_pkg::FREQ_W-1:0]     lo_freq_hz,
    output logic                           done,
    output logic                           in_range,
    output logic [sdc_pkg::BAND_W-1:0]     band_code,
    output logic [sdc_pkg::INT_W-1:0]      int_divider,
    output logic [sdc_pkg::HALF_W-1:0]     frac_high,
    output logic [sdc_pkg::HALF_W-1:0]     frac_low,
    input  logic                           cfg_we,
    input  logic [sdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sdc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [sdc_pkg::STEP_W-1:0] pll_step_reg;
    sdc_pkg::edges_t            edges_reg;

    // Chain wiring: entry 0 is the band stage, entry i+1 the output of cell i.
    logic            chain_valid [sdc_pkg::DIV_STEPS+1];
    sdc_pkg::stage_t chain_stage [sdc_pkg::DIV_STEPS+1];

    // Output register.
    logic                       done_reg;
    logic                       in_range_reg;
    logic [sdc_pkg::BAND_W-1:0] band_code_reg;
    logic [sdc_pkg::INT_W-1:0]  int_divider_reg;
    logic [sdc_pkg::HALF_W-1:0] frac_high_reg;
    logic [sdc_pkg::HALF_W-1:0] frac_low_reg;

    sdc_pkg::stage_t            last_stage;
    logic                       in_beat;

    assign busy    = 1'b0;
    assign in_beat = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pll_step_reg <= sdc_pkg::PLL_STEP_RST;
            edges_reg[0] <= sdc_pkg::EDGE_0_RST;
            edges_reg[1] <= sdc_pkg::EDGE_1_RST;
            edges_reg[2] <= sdc_pkg::EDGE_2_RST;
            edges_reg[3] <= sdc_pkg::EDGE_3_RST;
            edges_reg[4] <= sdc_pkg::EDGE_4_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdc_pkg::REG_PLL_STEP: pll_step_reg <= cfg_data[sdc_pkg::STEP_W-1:0];
                sdc_pkg::REG_EDGE_0:   edges_reg[0] <= cfg_data;
                sdc_pkg::REG_EDGE_1:   edges_reg[1] <= cfg_data;
                sdc_pkg::REG_EDGE_2:   edges_reg[2] <= cfg_data;
                sdc_pkg::REG_EDGE_3:   edges_reg[3] <= cfg_data;
                sdc_pkg::REG_EDGE_4:   edges_reg[4] <= cfg_data;
                default: ;   // drop writes to unused indexes
            endcase
        end
    end

    // Classify the frequency and seed the dividend.
    sdc_band_sel u_band_sel
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_beat),
        .freq      (lo_freq_hz),
        .edges     (edges_reg),
        .out_valid (chain_valid[0]),
        .out_stage (chain_stage[0])
    );

    // Row of restoring-division cells, MSB of the quotient first. The user must
    // change the step register only while the chain is empty; the block itself
    // does not enforce this, and every cell reads the register directly.
    for (genvar i = 0; i < sdc_pkg::DIV_STEPS; i++)
    begin : g_cell
        sdc_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .divisor   (pll_step_reg),
            .out_valid (chain_valid[i+1]),
            .out_stage (chain_stage[i+1])
        );
    end

    assign last_stage = chain_stage[sdc_pkg::DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[sdc_pkg::DIV_STEPS];
        end
    end

    // Split the quotient; zero every field when out of band.
    always_ff @(posedge clk)
    begin
        in_range_reg <= last_stage.ok;
        if (last_stage.ok)
        begin
            band_code_reg   <= last_stage.band;
            int_divider_reg <= last_stage.quo[sdc_pkg::FRAC_BITS +: sdc_pkg::INT_W];
            frac_high_reg   <= last_stage.quo[sdc_pkg::HALF_W +: sdc_pkg::HALF_W];
            frac_low_reg    <= last_stage.quo[0 +: sdc_pkg::HALF_W];
        end
        else
        begin
            band_code_reg   <= '0;
            int_divider_reg <= '0;
            frac_high_reg   <= '0;
            frac_low_reg    <= '0;
        end
    end

    assign done        = done_reg;
    assign in_range    = in_range_reg;
    assign band_code   = band_code_reg;
    assign int_divider = int_divider_reg;
    assign frac_high   = frac_high_reg;
    assign frac_low    = frac_low_reg;

endmodule

/* design/sdc_band_sel.sv */
// Front stage: band lookup against the NUM_EDGES band edges and chain entry register.
// Depends on sdc_pkg.
module sdc_band_sel
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [sdc_pkg::FREQ_W-1:0] freq,
    input  sdc_pkg::edges_t           edges,
    output logic                      out_valid,
    output sdc_pkg::stage_t           out_stage
);

    logic                       valid_reg;
    sdc_pkg::stage_t            stage_reg;
    sdc_pkg::stage_t            stage_next;
    logic [sdc_pkg::NUM_BANDS-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < sdc_pkg::NUM_BANDS; k++)
        begin
            hit[k] = (freq >= edges[k]) && (freq < edges[k+1]);
        end
    end

    // Lowest matching band wins.
    always_comb
    begin
        stage_next      = '0;
        stage_next.num  = freq;
        for (int k = sdc_pkg::NUM_BANDS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                stage_next.ok   = 1'b1;
                stage_next.band = k[sdc_pkg::BAND_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

/* design/sdc_div_cell.sv */
// One restoring-division cell: consume one dividend bit, emit one quotient bit.
// Depends on sdc_pkg.
module sdc_div_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  sdc_pkg::stage_t            in_stage,
    input  logic [sdc_pkg::STEP_W-1:0] divisor,
    output logic                       out_valid,
    output sdc_pkg::stage_t            out_stage
);

    logic                      valid_reg;
    sdc_pkg::stage_t           stage_reg;
    sdc_pkg::stage_t           stage_next;
    logic [sdc_pkg::REM_W-1:0] rem_shift;
    logic [sdc_pkg::REM_W:0]   trial;
    logic                      qbit;

    always_comb
    begin
        rem_shift  = {in_stage.rem[sdc_pkg::REM_W-2:0],
                      in_stage.num[sdc_pkg::FREQ_W-1]};
        trial      = {1'b0, rem_shift} - {2'b00, divisor};
        qbit       = ~trial[sdc_pkg::REM_W];
        stage_next = in_stage;
        // Advance the dividend, zeros fill in for the fraction bits.
        stage_next.num = {in_stage.num[sdc_pkg::FREQ_W-2:0], 1'b0};
        stage_next.rem = qbit ? trial[sdc_pkg::REM_W-1:0] : rem_shift;
        stage_next.quo = {in_stage.quo[sdc_pkg::Q_KEEP-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

/* design/sdc_checker.sv */
// Port-level checker for synth_divider_calc_core, attached by bind below.
// Depends on sdc_pkg.
module sdc_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic                           in_range,
    input logic [sdc_pkg::BAND_W-1:0]     band_code,
    input logic [sdc_pkg::INT_W-1:0]      int_divider,
    input logic [sdc_pkg::HALF_W-1:0]     frac_high,
    input logic [sdc_pkg::HALF_W-1:0]     frac_low
);

    // Every accepted beat yields its result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(sdc_pkg::LATENCY) done)
        else $error("missing result after accepted beat");

    // No result without a beat that produced it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(sdc_pkg::LATENCY) !done)
        else $error("result without accepted beat");

    // Out-of-band results carry all-zero fields.
    a_out_of_band_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (band_code == '0 && int_divider == '0 &&
                                 frac_high == '0 && frac_low == '0))
        else $error("out-of-band result has nonzero fields");

    // The block can take a beat in every cycle: busy never rises.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind synth_divider_calc_core sdc_checker u_sdc_checker (.*);
